@@ rtl/scse_pkg.sv @@
// Shared types and constants for the second chance slot evictor.
// No dependencies.
package scse_pkg;
   localparam int MAX_SLOTS_DEF = 64;
   localparam int GEN_BITS_DEF  = 16;

   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_LOAD  = 3'd1;
   localparam logic [2:0] ACT_EVICT = 3'd2;
   localparam logic [2:0] ACT_REF   = 3'd3;
   localparam logic [2:0] ACT_WRITE = 3'd4;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_BAD      = 3'd1;
   localparam logic [2:0] ST_GEN      = 3'd2;
   localparam logic [2:0] ST_WRONG    = 3'd3;
   localparam logic [2:0] ST_PINNED   = 3'd4;
   localparam logic [2:0] ST_LOADFAIL = 3'd5;

   localparam logic [1:0] CSR_SLOTS = 2'd0;
   localparam logic [1:0] CSR_EVT   = 2'd1;
   localparam logic [1:0] CSR_CPT   = 2'd2;

   typedef struct packed {
      logic cap_item;   // register the accepted item
      logic single;     // run a load, evict, reference or write action
      logic press_start;// start the pressure products
      logic sweep_init; // load sweep counters and start hand reduction
      logic sweep_step; // visit one slot
      logic clr_init;   // start referenced-clear pass
      logic clr_step;   // clear one slot
      logic post;       // present result
   } scse_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic press_done;
      logic pressure;
      logic count_zero;
      logic hand_ready;
      logic sweep_done;
      logic clr_done;
   } scse_sts_type;
endpackage

@@ rtl/scse_ctrl.sv @@
// Controller state machine for the slot evictor.
// Depends on scse_pkg.
module scse_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  scse_pkg::scse_sts_type sts,
   output scse_pkg::scse_cmd_type cmd
);
   import scse_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DEC   = 7'b0000010,
      S_PRESS = 7'b0000100,
      S_SWEEP = 7'b0001000,
      S_CLEAR = 7'b0010000,
      S_OUT   = 7'b0100000,
      S_WAIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   // The output register frees once the result is taken, so a new item enters
   // only when no result waits or the waiting result is taken in the same cycle.
   assign req_tready = (state_ff == S_IDLE) && (!out_valid_ff || rsp_tready);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.cap_item = 1'b1;
               state_in     = S_DEC;
            end
         end
         S_DEC: begin
            if (!sts.is_tick) begin
               cmd.single = 1'b1;
               state_in   = S_OUT;
            end else begin
               cmd.press_start = 1'b1;
               state_in        = S_PRESS;
            end
         end
         S_PRESS: begin
            if (sts.press_done) begin
               if (sts.count_zero) begin
                  state_in = S_OUT;
               end else if (sts.pressure) begin
                  cmd.sweep_init = 1'b1;
                  state_in       = S_SWEEP;
               end else begin
                  cmd.clr_init = 1'b1;
                  state_in     = S_CLEAR;
               end
            end
         end
         S_SWEEP: begin
            // The hand is first brought within the slot count.
            if (sts.hand_ready) begin
               if (sts.sweep_done) begin
                  cmd.clr_init = 1'b1;
                  state_in     = S_CLEAR;
               end else begin
                  cmd.sweep_step = 1'b1;
               end
            end
         end
         S_CLEAR: begin
            if (sts.clr_done) begin
               state_in = S_OUT;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.post     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WAIT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

@@ rtl/scse_dp.sv @@
// Datapath for the slot evictor: slot table, clock hand, pressure test.
// Depends on scse_pkg.
module scse_dp #(
   parameter int MAX_SLOTS = scse_pkg::MAX_SLOTS_DEF,
   parameter int GEN_BITS  = scse_pkg::GEN_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scse_pkg::scse_cmd_type cmd,
   output scse_pkg::scse_sts_type sts,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic [2:0]             in_action,
   input  logic [5:0]             in_slot,
   input  logic [15:0]            in_generation,
   input  logic                   in_load_ok,
   input  logic                   in_pinned,
   input  logic                   in_resident,
   input  logic [31:0]            in_vertex_used,
   input  logic [31:0]            in_vertex_capacity,
   input  logic [31:0]            in_index_used,
   input  logic [31:0]            in_index_capacity,
   input  logic [16:0]            in_fragmentation,
   output logic [2:0]             out_status,
   output logic                   out_evicted,
   output logic [5:0]             out_evicted_slot,
   output logic                   out_compact
);
   import scse_pkg::*;

   localparam int IW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);

   // Generations live in a memory; a per-slot nonzero flag, cleared at reset,
   // marks which entries hold a live generation, so the memory needs no clearing.
   logic [GEN_BITS-1:0] gen_mem [MAX_SLOTS];
   logic [GEN_BITS-1:0] gen_rd_ff;
   logic [MAX_SLOTS-1:0] nz_ff, res_ff, pin_ff, ref_ff;
   logic [IW-1:0] hand_ff;
   logic          compact_ff;
   logic [6:0]    slots_cfg_ff;
   logic [15:0]   evt_ff, cpt_ff;

   // Registered item.
   logic [2:0]  act_ff;
   logic [5:0]  slot_ff;
   logic [15:0] genin_ff;
   logic        ok_ff, pinin_ff, resin_ff;
   logic [31:0] vu_ff, vc_ff, iu_ff, ic_ff;
   logic [16:0] frag_ff;

   logic [47:0] vl_ff, vr_ff, il_ff, ir_ff;
   logic        press_ph_ff;
   logic [CW-1:0] cnt_ff;     // effective count
   logic [CW-1:0] visit_ff;
   logic          found_ff;
   logic [IW-1:0] clr_ff;
   logic [CW-1:0] clr_n_ff;
   logic [7:0]    mod_left_ff;

   logic [2:0] st_ff;
   logic       ev_ff;
   logic [IW-1:0] vic_ff;

   logic [CW-1:0] count;
   assign count = (CW'(slots_cfg_ff) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(slots_cfg_ff);

   logic [GEN_BITS-1:0] gmask;
   assign gmask = GEN_BITS'(genin_ff);

   logic        slot_in_cnt, slot_in_tab;
   logic [IW-1:0] sidx;
   assign slot_in_cnt = {26'd0, slot_ff} < 32'(count);
   assign slot_in_tab = {26'd0, slot_ff} < 32'(MAX_SLOTS);
   assign sidx = IW'(slot_ff);

   logic vpress, ipress;
   assign vpress = (vc_ff != 32'd0) && (vl_ff > vr_ff);
   assign ipress = (ic_ff != 32'd0) && (il_ff > ir_ff);

   // Before a sweep the hand is reduced modulo the count by one shifted
   // compare and subtract per cycle, highest shift first.
   logic [7:0]  mod_sh;
   logic [31:0] mod_sub;
   assign mod_sh  = mod_left_ff - 8'd1;
   assign mod_sub = 32'(cnt_ff) << mod_sh;

   logic [IW-1:0] sweep_i, sweep_nx;
   assign sweep_i  = hand_ff;
   assign sweep_nx = (32'(hand_ff) + 1 >= 32'(cnt_ff)) ? '0 : IW'(hand_ff + 1'b1);

   assign sts.is_tick    = (act_ff == ACT_TICK);
   assign sts.press_done = press_ph_ff;
   assign sts.pressure   = vpress || ipress;
   assign sts.count_zero = (count == '0);
   assign sts.hand_ready = (mod_left_ff == 8'd0);
   assign sts.sweep_done = found_ff || (visit_ff == cnt_ff);
   assign sts.clr_done   = ({1'b0, clr_n_ff} == '0) || (32'(clr_ff) + 1 > 32'(clr_n_ff));

   always_ff @(posedge clock) begin
      if (cmd.cap_item) begin
         act_ff  <= in_action;   slot_ff <= in_slot;   genin_ff <= in_generation;
         ok_ff   <= in_load_ok;  pinin_ff <= in_pinned; resin_ff <= in_resident;
         vu_ff   <= in_vertex_used; vc_ff <= in_vertex_capacity;
         iu_ff   <= in_index_used;  ic_ff <= in_index_capacity;
         frag_ff <= in_fragmentation;
         gen_rd_ff <= gen_mem[IW'(in_slot)];
      end
      if (cmd.single && act_ff == ACT_WRITE && slot_in_tab) gen_mem[sidx] <= gmask;
      if (cmd.press_start) begin
         vl_ff <= {vu_ff, 16'd0};
         il_ff <= {iu_ff, 16'd0};
         vr_ff <= evt_ff * vc_ff;
         ir_ff <= evt_ff * ic_ff;
      end
      if (cmd.post) begin
         out_status       <= st_ff;
         out_evicted      <= ev_ff;
         out_evicted_slot <= ev_ff ? 6'(vic_ff) : 6'd0;
         out_compact      <= compact_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_ff <= '0; res_ff <= '0; pin_ff <= '0; ref_ff <= '0;
         hand_ff <= '0; compact_ff <= 1'b0;
         slots_cfg_ff <= 7'd64; evt_ff <= 16'd58982; cpt_ff <= 16'd19661;
         press_ph_ff <= 1'b0; found_ff <= 1'b0; mod_left_ff <= '0;
         visit_ff <= '0; cnt_ff <= '0; clr_ff <= '0; clr_n_ff <= '0;
         st_ff <= ST_DONE; ev_ff <= 1'b0; vic_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SLOTS: slots_cfg_ff <= csr_wdata[6:0];
               CSR_EVT:   evt_ff <= csr_wdata;
               CSR_CPT:   cpt_ff <= csr_wdata;
               default:   ;
            endcase
         end
         press_ph_ff <= cmd.press_start;
         if (cmd.press_start) begin
            st_ff <= ST_DONE; ev_ff <= 1'b0;
            if (frag_ff > {1'b0, cpt_ff}) compact_ff <= 1'b1;
         end
         if (cmd.single) begin
            case (act_ff)
               ACT_LOAD, ACT_EVICT: begin
                  if (gmask == '0 || !slot_in_cnt) begin
                     st_ff <= ST_BAD; ev_ff <= 1'b0;
                  end else if (!nz_ff[sidx] || gen_rd_ff != gmask) begin
                     st_ff <= ST_GEN; ev_ff <= 1'b0;
                  end else if (act_ff == ACT_LOAD) begin
                     ev_ff <= 1'b0;
                     if (res_ff[sidx]) st_ff <= ST_WRONG;
                     else if (!ok_ff) st_ff <= ST_LOADFAIL;
                     else begin
                        st_ff <= ST_DONE; res_ff[sidx] <= 1'b1;
                     end
                  end else begin
                     if (!res_ff[sidx]) begin
                        st_ff <= ST_WRONG; ev_ff <= 1'b0;
                     end else if (pin_ff[sidx]) begin
                        st_ff <= ST_PINNED; ev_ff <= 1'b0;
                     end else begin
                        st_ff <= ST_DONE;
                        res_ff[sidx] <= 1'b0; ev_ff <= 1'b1; vic_ff <= sidx;
                     end
                  end
               end
               ACT_REF: begin
                  ev_ff <= 1'b0;
                  if (!slot_in_cnt) st_ff <= ST_BAD;
                  else begin
                     st_ff <= ST_DONE; ref_ff[sidx] <= 1'b1;
                  end
               end
               ACT_WRITE: begin
                  ev_ff <= 1'b0;
                  if (!slot_in_tab) st_ff <= ST_BAD;
                  else begin
                     st_ff <= ST_DONE;
                     nz_ff[sidx] <= (gmask != '0); pin_ff[sidx] <= pinin_ff;
                     res_ff[sidx] <= resin_ff; ref_ff[sidx] <= 1'b0;
                  end
               end
               default: begin
                  st_ff <= ST_BAD; ev_ff <= 1'b0;
               end
            endcase
         end
         if (cmd.sweep_init) begin
            cnt_ff <= count; visit_ff <= '0; found_ff <= 1'b0;
            mod_left_ff <= 8'(IW);
         end
         if (mod_left_ff != 8'd0) begin
            if (32'(hand_ff) >= mod_sub) hand_ff <= IW'(32'(hand_ff) - mod_sub);
            mod_left_ff <= mod_left_ff - 8'd1;
         end
         if (cmd.sweep_step) begin
            visit_ff <= visit_ff + 1'b1;
            hand_ff  <= sweep_nx;
            if (nz_ff[sweep_i] && res_ff[sweep_i] && !pin_ff[sweep_i]) begin
               if (ref_ff[sweep_i]) ref_ff[sweep_i] <= 1'b0;
               else begin
                  res_ff[sweep_i] <= 1'b0; found_ff <= 1'b1;
                  ev_ff <= 1'b1; vic_ff <= sweep_i;
               end
            end
         end
         if (cmd.clr_init) begin
            clr_ff <= '0; clr_n_ff <= count;
         end
         if (cmd.clr_step) begin
            if (nz_ff[clr_ff] && res_ff[clr_ff]) ref_ff[clr_ff] <= 1'b0;
            clr_ff <= clr_ff + 1'b1;
            if (32'(clr_ff) + 1 >= 32'(clr_n_ff)) clr_n_ff <= '0;
         end
      end
   end
endmodule

@@ rtl/second_chance_slot_evictor.sv @@
// Second chance slot evictor. One item is handled at a time. A load, evict,
// reference or write item is captured, run as a single action and its
// result posted. A tick with a slot count of zero posts its result right
// after the pressure test. Otherwise, when either pool is under pressure,
// the clock hand is first brought within the count and slots are then
// visited until a victim is found or all have been visited; every such
// tick ends with a pass that clears the referenced flags of resident
// slots in use. A stalled result holds off the next item. Slot flags live
// in flip-flops and generations in a memory whose live entries are tracked
// by flags cleared at reset, so no clearing pass is needed. Every item gives
// exactly one result item. Depends on scse_pkg, scse_ctrl and scse_dp.
module second_chance_slot_evictor #(
   parameter int MAX_SLOTS = scse_pkg::MAX_SLOTS_DEF,
   parameter int GEN_BITS  = scse_pkg::GEN_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action, slot, generation, load_ok, pinned, resident, vertex_used,
   // vertex_capacity, index_used, index_capacity, fragmentation; zero pad
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, evicted, evicted_slot, compact_requested; zero pad
   output logic [15:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import scse_pkg::*;

   scse_cmd_type cmd;
   scse_sts_type sts;
   logic [2:0] st;
   logic       ev, cp;
   logic [5:0] evs;

   scse_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .sts(sts), .cmd(cmd)
   );

   scse_dp #(.MAX_SLOTS(MAX_SLOTS), .GEN_BITS(GEN_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_action(req_tdata[2:0]), .in_slot(req_tdata[8:3]),
      .in_generation(req_tdata[24:9]), .in_load_ok(req_tdata[25]),
      .in_pinned(req_tdata[26]), .in_resident(req_tdata[27]),
      .in_vertex_used(req_tdata[59:28]), .in_vertex_capacity(req_tdata[91:60]),
      .in_index_used(req_tdata[123:92]), .in_index_capacity(req_tdata[155:124]),
      .in_fragmentation(req_tdata[172:156]),
      .out_status(st), .out_evicted(ev), .out_evicted_slot(evs), .out_compact(cp)
   );

   assign rsp_tdata = {5'd0, cp, evs, ev, st};
endmodule
